FILE: rtl/core/sad_min_offset_search_assert.svh
// ----------------------------------------------------------------------------
// SAD search assertion macros
// Concurrent assertion wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SAD_MIN_OFFSET_SEARCH_ASSERT_SVH
`define SAD_MIN_OFFSET_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// property holds at every edge outside reset
`define SMS_ASSERT(name, clk_s, rst_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("%m: assertion failed");

// antecedent implies consequent on the next edge
`define SMS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define SMS_ASSERT(name, clk_s, rst_s, prop)
`define SMS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)

`endif

`endif

FILE: rtl/core/sms_pkg.sv
// ----------------------------------------------------------------------------
// SAD search package
// Word types, command and register codes, controller states.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 14;
  localparam int LIMIT_W  = 16;
  localparam int BUFLEN_W = 15;

  // command codes carried in request.command
  localparam logic [1:0] CMD_WRITE_TEMPLATE = 2'd0;
  localparam logic [1:0] CMD_WRITE_BUFFER   = 2'd1;
  localparam logic [1:0] CMD_SEARCH         = 2'd2;
  localparam logic [1:0] CMD_RESERVED       = 2'd3;  // ignored, no result

  // configuration register indexes
  localparam logic [1:0] CFG_BUFFER_LENGTH = 2'd0;
  localparam logic [1:0] CFG_INITIAL_LIMIT = 2'd1;

  localparam logic [BUFLEN_W-1:0] BUFFER_LENGTH_RST = 15'd16384;
  localparam logic [LIMIT_W-1:0]  INITIAL_LIMIT_RST = 16'd400;

  typedef struct packed {
    logic [1:0]                 command;
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] sample;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
    logic [LIMIT_W-1:0] best_distance;
  } result_t;

  // travels with each read pair through the accumulator pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } sad_tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/sms_ram.sv
// ----------------------------------------------------------------------------
// SAD search generic RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/sms_sad_acc.sv
// ----------------------------------------------------------------------------
// SAD search accumulator
// Absolute difference of two RAM read words, summed over one window.
// ----------------------------------------------------------------------------
module sms_sad_acc
  import sms_pkg::*;
#(
  parameter int SUM_W = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  sad_tag_t            tag,       // aligned with the RAM address cycle
  input  logic [SAMPLE_W-1:0] tmpl_data,
  input  logic [SAMPLE_W-1:0] buf_data,
  output logic [SUM_W-1:0]    sum,
  output logic                sum_valid
);

  sad_tag_t             tag_d1;
  sad_tag_t             tag_d2;
  logic [SAMPLE_W-1:0]  absdiff;
  logic [SUM_W-1:0]     acc;
  logic [SUM_W-1:0]     acc_next;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]    mag;

  always_comb begin
    diff = $signed({tmpl_data[SAMPLE_W-1], tmpl_data}) -
           $signed({buf_data[SAMPLE_W-1], buf_data});
    mag  = diff[SAMPLE_W] ? $unsigned(-diff) : $unsigned(diff);
    acc_next = (tag_d2.first ? '0 : acc) + SUM_W'(absdiff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d1    <= '0;
      tag_d2    <= '0;
      sum_valid <= 1'b0;
    end else begin
      tag_d1    <= tag;
      tag_d2    <= tag_d1;
      sum_valid <= tag_d2.valid & tag_d2.last;
    end
  end

  always_ff @(posedge clk) begin
    absdiff <= mag[SAMPLE_W-1:0];  // |d| <= 65535
    if (tag_d2.valid) begin
      acc <= acc_next;
    end
  end

  assign sum = acc;

endmodule

FILE: rtl/core/sad_min_offset_search.sv
// ----------------------------------------------------------------------------
// SAD minimum-offset search
// Template match by sum of absolute differences over a sample buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a request word is taken when start is high and busy is
//   low. Template and buffer writes complete in that cycle and leave busy low,
//   so samples can stream in at one word per clock. A search raises busy
//   until its result word has been shown.
//   Result channel: done is high for exactly one cycle with the result word;
//   the receiver has no way to stall it. Only searches give a result.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   low while a search runs.
// Offset walk:
//   Each offset reads one template/buffer RAM read pair per cycle through a
//   single port on each memory, then passes the RAM read register, the
//   difference register and the accumulator before the compare. A search
//   ends early once the best reaches zero, and goes straight to its result
//   when the buffer is shorter than the window.
// Reset: registers return to their reset values; RAM contents are kept and
//   are undefined until written.
// ----------------------------------------------------------------------------
`include "sad_min_offset_search_assert.svh"

module sad_min_offset_search
  import sms_pkg::*;
#(
  parameter int WINDOW_LEN   = 400,
  parameter int BUFFER_DEPTH = 16384,
  parameter int FRAC_BITS    = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  request_t     request,
  output logic         done,
  output result_t      result,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int TA_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int BA_W  = $clog2(BUFFER_DEPTH);
  localparam int SUM_W = $clog2(WINDOW_LEN + 1) + SAMPLE_W;
  localparam int CMP_W = (SUM_W > LIMIT_W + FRAC_BITS) ? SUM_W : LIMIT_W + FRAC_BITS;

  // configuration
  logic [BUFLEN_W-1:0] buffer_length;
  logic [LIMIT_W-1:0]  initial_limit;

  // search state
  state_t              state, state_next;
  logic [LIMIT_W-1:0]  best, best_next;
  logic [BA_W-1:0]     best_off, best_off_next;
  logic                found, found_next;
  logic [BA_W-1:0]     off, off_next;
  logic [BA_W-1:0]     last_off, last_off_next;
  logic [TA_W-1:0]     rd_cnt, rd_cnt_next;

  // RAM ports
  logic                tmpl_we, buf_we;
  logic [TA_W-1:0]     tmpl_addr;
  logic [BA_W-1:0]     buf_addr;
  logic [SAMPLE_W-1:0] tmpl_rdata, buf_rdata;

  sad_tag_t            tag;
  logic [SUM_W-1:0]    sum;
  logic                sum_valid;

  logic                accept;
  logic [31:0]         idx_w;
  logic [31:0]         len_eff;
  logic [31:0]         last32;
  logic [31:0]         raddr32;
  logic [31:0]         pos32;
  logic                have_window;
  logic [CMP_W-1:0]    sum_cmp, limit_cmp;
  logic                beats;
  logic [LIMIT_W-1:0]  cand;
  logic                rd_last;
  logic                stop;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= BUFFER_LENGTH_RST;
      initial_limit <= INITIAL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BUFFER_LENGTH: buffer_length <= cfg_data[BUFLEN_W-1:0];
        CFG_INITIAL_LIMIT: initial_limit <= cfg_data;
        default: ;  // unused index: dropped
      endcase
    end
  end

  always_comb begin
    idx_w       = 32'(request.index);
    // lengths beyond the buffer clamp to its depth
    len_eff     = (32'(buffer_length) > 32'(BUFFER_DEPTH)) ? 32'(BUFFER_DEPTH)
                                                           : 32'(buffer_length);
    have_window = (len_eff >= 32'(WINDOW_LEN));
    last32      = len_eff - 32'(WINDOW_LEN);
    raddr32     = 32'(off) + 32'(rd_cnt);  // stays below len_eff
    pos32       = 32'(best_off);
    rd_last     = (rd_cnt == TA_W'(WINDOW_LEN - 1));

    // exact compare: sum < best * 2^FRAC_BITS
    sum_cmp   = CMP_W'(sum);
    limit_cmp = CMP_W'(best) << FRAC_BITS;
    beats     = (sum_cmp < limit_cmp);
    cand      = LIMIT_W'(sum >> FRAC_BITS);  // truncated, below old best
    stop      = (beats ? (cand == '0) : (best == '0)) || (off == last_off);
  end

  always_comb begin
    state_next    = state;
    best_next     = best;
    best_off_next = best_off;
    found_next    = found;
    off_next      = off;
    last_off_next = last_off;
    rd_cnt_next   = rd_cnt;
    tmpl_we       = 1'b0;
    buf_we        = 1'b0;
    tmpl_addr     = idx_w[TA_W-1:0];
    buf_addr      = idx_w[BA_W-1:0];
    tag           = '0;
    done          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (request.command)
            CMD_WRITE_TEMPLATE: tmpl_we = (idx_w < 32'(WINDOW_LEN));
            CMD_WRITE_BUFFER:   buf_we  = (idx_w < 32'(BUFFER_DEPTH));
            CMD_SEARCH: begin
              best_next     = initial_limit;
              best_off_next = '0;
              found_next    = 1'b0;
              off_next      = '0;
              rd_cnt_next   = '0;
              last_off_next = last32[BA_W-1:0];
              state_next    = have_window ? ST_READ : ST_DONE;
            end
            default: ;  // unused command: no effect, no result
          endcase
        end
      end

      // one template/buffer read pair per cycle for the current offset
      ST_READ: begin
        tmpl_addr = rd_cnt;
        buf_addr  = raddr32[BA_W-1:0];
        tag.valid = 1'b1;
        tag.first = (rd_cnt == '0);
        tag.last  = rd_last;
        if (rd_last) begin
          rd_cnt_next = '0;
          state_next  = ST_WAIT;
        end else begin
          rd_cnt_next = rd_cnt + TA_W'(1);
        end
      end

      // wait for the window sum through the RAM read, difference and accumulator registers
      ST_WAIT: begin
        if (sum_valid) begin
          if (beats) begin
            best_next     = cand;
            best_off_next = off;
            found_next    = 1'b1;
          end
          if (stop) begin
            state_next = ST_DONE;
          end else begin
            off_next   = off + BA_W'(1);
            state_next = ST_READ;
          end
        end
      end

      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      best     <= '0;
      best_off <= '0;
      found    <= 1'b0;
      off      <= '0;
      last_off <= '0;
      rd_cnt   <= '0;
    end else begin
      state    <= state_next;
      best     <= best_next;
      best_off <= best_off_next;
      found    <= found_next;
      off      <= off_next;
      last_off <= last_off_next;
      rd_cnt   <= rd_cnt_next;
    end
  end

  assign result.found         = found;
  assign result.position      = pos32[INDEX_W-1:0];
  assign result.best_distance = best;

  sms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_tmpl_ram (
    .clk   (clk),
    .we    (tmpl_we),
    .addr  (tmpl_addr),
    .wdata ($unsigned(request.sample)),
    .rdata (tmpl_rdata)
  );

  sms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .addr  (buf_addr),
    .wdata ($unsigned(request.sample)),
    .rdata (buf_rdata)
  );

  sms_sad_acc #(
    .SUM_W (SUM_W)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .tag       (tag),
    .tmpl_data (tmpl_rdata),
    .buf_data  (buf_rdata),
    .sum       (sum),
    .sum_valid (sum_valid)
  );

  // window sums only arrive while the controller waits for them
  `SMS_ASSERT(a_sum_in_wait, clk, rst, !sum_valid || state == ST_WAIT)
  // the result cycle releases the command channel
  `SMS_ASSERT_NEXT(a_done_frees, clk, rst, done, !busy)
  // the running best never grows
  `SMS_ASSERT_NEXT(a_best_monotone, clk, rst, state == ST_WAIT && sum_valid, best <= $past(best))
  // a reported match is below the starting limit
  `SMS_ASSERT(a_found_below, clk, rst, !(done && result.found) || result.best_distance < initial_limit)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SAD minimum-offset search testbench
// Loads a template and a short search buffer, then runs directed and random
// searches across buffer lengths and limits. Every search result word is
// compared field by field to a hand-written word or the offset-walk predictor.
// ----------------------------------------------------------------------------
module testbench;
  import sms_pkg::*;

  localparam int WINDOW_LEN   = 400;
  localparam int BUFFER_DEPTH = 16384;
  localparam int FRAC_BITS    = 12;

  // Only buffer entries 0..LOADED_LEN-1 are guaranteed written, so every
  // search that walks more than offset 0 keeps buffer_length at or below this.
  localparam int LOADED_LEN   = 424;
  // The preload copies the template into the buffer starting here, giving a
  // known exact match for the early-stop case.
  localparam int MATCH_AT     = 5;
  localparam int ITEM_TARGET  = 1700;
  // Longest correct quiet stretch is one full search of 25 offsets; allow
  // several times that.
  localparam int STALL_LIMIT  = 40000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  request_t    request;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  sad_min_offset_search #(
    .WINDOW_LEN   (WINDOW_LEN),
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // bench copy of the block state: both sample memories and both registers
  logic signed [15:0] tmpl_mem  [WINDOW_LEN];
  logic signed [15:0] trace_mem [BUFFER_DEPTH];
  int unsigned        len_reg;
  int unsigned        limit_reg;

  result_t awaited_results [$];
  result_t oldest;
  int      fail_count;
  int      words_sent;
  int      quiet_cycles = 0;
  int      idle_pct;

  // one line of the directed list: a register write or a request word,
  // optionally with a hand-written expected result
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  cfg_sel;
    logic [15:0] cfg_val;
    request_t    word;
    logic        typed;
    result_t     want;
  } plan_entry_t;

  plan_entry_t plan [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: walk offsets 0..len-WINDOW_LEN, accept a strictly lower sum,
  // truncate the new best to whole units, stop once the best hits zero.
  // --------------------------------------------------------------------------
  function automatic result_t search_outcome();
    int unsigned     eff_len;
    int unsigned     last_off;
    int unsigned     off;
    int unsigned     i;
    int unsigned     best;
    int unsigned     best_off;
    longint unsigned acc;
    int              d;
    logic            hit;
    result_t         r;
    eff_len  = (len_reg > BUFFER_DEPTH) ? BUFFER_DEPTH : len_reg;
    best     = limit_reg;
    best_off = 0;
    hit      = 1'b0;
    if (eff_len >= WINDOW_LEN) begin
      last_off = eff_len - WINDOW_LEN;
      for (off = 0; off <= last_off; off++) begin
        acc = 0;
        for (i = 0; i < WINDOW_LEN; i++) begin
          d = int'(tmpl_mem[i]) - int'(trace_mem[off + i]);
          acc += longint'((d < 0) ? -d : d);
        end
        if (acc < (longint'(best) << FRAC_BITS)) begin
          best     = int'(acc >> FRAC_BITS);
          best_off = off;
          hit      = 1'b1;
        end
        if (best == 0) break;
      end
    end
    r.found         = hit;
    r.position      = best_off[INDEX_W-1:0];
    r.best_distance = best[LIMIT_W-1:0];
    return r;
  endfunction

  function automatic request_t word_of(logic [1:0] cmd, int idx, logic [15:0] smp);
    request_t w;
    w.command = cmd;
    w.index   = idx[INDEX_W-1:0];
    w.sample  = smp;
    return w;
  endfunction

  function automatic plan_entry_t as_cfg(logic [1:0] sel, logic [15:0] val);
    plan_entry_t e;
    e         = '0;
    e.is_cfg  = 1'b1;
    e.cfg_sel = sel;
    e.cfg_val = val;
    return e;
  endfunction

  function automatic plan_entry_t as_word(request_t w, logic typed, result_t want);
    plan_entry_t e;
    e       = '0;
    e.word  = w;
    e.typed = typed;
    e.want  = want;
    return e;
  endfunction

  // mostly bounded amplitude so sums land near useful limits; a quarter of
  // the draws span the whole 16-bit range to exercise every sample bit
  function automatic logic [15:0] draw_sample(int amp);
    int v;
    if ($urandom_range(3) == 0) return 16'($urandom_range(0, 65535));
    v = int'($urandom_range(0, 2 * amp)) - amp;
    return v[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Command channel driver. Entered just after a falling edge; start is left
  // high on return so back-to-back words stream with no bubble, and the next
  // caller decides its value in that same step.
  // --------------------------------------------------------------------------
  task automatic issue(request_t w, logic typed, result_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    // word taken at this edge: update the bench state to match
    words_sent++;
    case (w.command)
      CMD_WRITE_TEMPLATE: if (w.index < WINDOW_LEN) tmpl_mem[w.index] = w.sample;
      CMD_WRITE_BUFFER:   trace_mem[w.index] = w.sample;
      CMD_SEARCH:         awaited_results.push_back(typed ? want : search_outcome());
      default: ;
    endcase
    @(negedge clk);
  endtask

  // drop start, drain outstanding searches, then a short margin of quiet
  task automatic settle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic write_reg(logic [1:0] sel, logic [15:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (sel == CFG_BUFFER_LENGTH) len_reg = 32'(val[BUFLEN_W-1:0]);
    else limit_reg = 32'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every done pulse must match the oldest expected word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word: found %0b position %0d best %0d",
                 $time, result.found, result.position, result.best_distance);
        fail_count++;
      end else begin
        oldest = awaited_results.pop_front();
        if (result.found !== oldest.found) begin
          $display("%0t: found expected %0b got %0b", $time, oldest.found, result.found);
          fail_count++;
        end
        if (result.position !== oldest.position) begin
          $display("%0t: position expected %0d got %0d",
                   $time, oldest.position, result.position);
          fail_count++;
        end
        if (result.best_distance !== oldest.best_distance) begin
          $display("%0t: best_distance expected %0d got %0d",
                   $time, oldest.best_distance, result.best_distance);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any handshake on any channel restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          i;
    int          seq;
    int          rand_base;
    int          amp;
    int          burst;
    int          roll;
    int          phase;
    logic [15:0] smp;
    request_t    w;
    plan_entry_t e;

    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_pct   = 0;
    fail_count = 0;
    words_sent = 0;
    len_reg    = 32'(BUFFER_LENGTH_RST);
    limit_reg  = 32'(INITIAL_LIMIT_RST);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Preload: full template, then buffer 0..LOADED_LEN-1 with the template
    // copied in at MATCH_AT so one offset is an exact match.
    for (i = 0; i < WINDOW_LEN; i++)
      issue(word_of(CMD_WRITE_TEMPLATE, i, draw_sample(2048)), 1'b0, '0);
    for (i = 0; i < LOADED_LEN; i++) begin
      if (i >= MATCH_AT && i < MATCH_AT + WINDOW_LEN) smp = tmpl_mem[i - MATCH_AT];
      else smp = draw_sample(2048);
      issue(word_of(CMD_WRITE_BUFFER, i, smp), 1'b0, '0);
    end

    // Directed list. Fixed expectations only where obvious; the rest goes
    // through the predictor.
    // limit zero at the full reset length: one offset, then stop
    plan.push_back(as_cfg(CFG_INITIAL_LIMIT, 16'd0));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b1, {1'b0, 14'd0, 16'd0}));
    // length past the buffer depth is clamped; limit zero keeps it to offset 0
    plan.push_back(as_cfg(CFG_BUFFER_LENGTH, 16'd32767));
    plan.push_back(as_word(word_of(CMD_SEARCH, 16383, 16'hFFFF), 1'b1,
                           {1'b0, 14'd0, 16'd0}));
    // buffer shorter than the window: no offset examined
    plan.push_back(as_cfg(CFG_INITIAL_LIMIT, 16'hFFFF));
    plan.push_back(as_cfg(CFG_BUFFER_LENGTH, 16'd1));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b1,
                           {1'b0, 14'd0, 16'd65535}));
    plan.push_back(as_cfg(CFG_BUFFER_LENGTH, 16'(WINDOW_LEN - 1)));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b1,
                           {1'b0, 14'd0, 16'd65535}));
    // exactly one offset with the widest limit
    plan.push_back(as_cfg(CFG_BUFFER_LENGTH, 16'(WINDOW_LEN)));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b0, '0));
    // exact match at MATCH_AT drives the best to zero and ends the walk early
    plan.push_back(as_cfg(CFG_BUFFER_LENGTH, 16'(LOADED_LEN)));
    plan.push_back(as_cfg(CFG_INITIAL_LIMIT, 16'd400));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b1,
                           {1'b1, 14'(MATCH_AT), 16'd0}));
    // break the match with full-scale differences at both window ends
    plan.push_back(as_word(word_of(CMD_WRITE_TEMPLATE, 0, 16'h7FFF), 1'b0, '0));
    plan.push_back(as_word(word_of(CMD_WRITE_BUFFER, MATCH_AT, 16'h8000), 1'b0, '0));
    plan.push_back(as_word(word_of(CMD_WRITE_TEMPLATE, WINDOW_LEN - 1, 16'h8000),
                           1'b0, '0));
    plan.push_back(as_word(word_of(CMD_WRITE_BUFFER, MATCH_AT + WINDOW_LEN - 1, 16'h7FFF),
                           1'b0, '0));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b0, '0));
    // words the block must ignore, plus a valid write at the top buffer index
    plan.push_back(as_word(word_of(CMD_RESERVED, 16383, 16'hFFFF), 1'b0, '0));
    plan.push_back(as_word(word_of(CMD_WRITE_TEMPLATE, WINDOW_LEN, 16'h1234), 1'b0, '0));
    plan.push_back(as_word(word_of(CMD_WRITE_TEMPLATE, 16383, 16'hFFFF), 1'b0, '0));
    plan.push_back(as_word(word_of(CMD_WRITE_BUFFER, 16383, 16'h0000), 1'b0, '0));
    // sum at MATCH_AT is 131070: just under 32 units, just over 31
    plan.push_back(as_cfg(CFG_INITIAL_LIMIT, 16'd32));
    plan.push_back(as_word(word_of(CMD_SEARCH, 0, 16'h0000), 1'b0, '0));
    plan.push_back(as_cfg(CFG_INITIAL_LIMIT, 16'd31));
    plan.push_back(as_word(word_of(CMD_SEARCH, 8191, 16'h8000), 1'b0, '0));

    foreach (plan[i]) begin
      e = plan[i];
      if (e.is_cfg) write_reg(e.cfg_sel, e.cfg_val);
      else issue(e.word, e.typed, e.want);
    end

    // Random part: bursts of writes with random content, each closed by a
    // search. Lengths stay inside the loaded region; settings change between
    // bursts. Idling runs through none / heavy / none / moderate phases.
    rand_base = words_sent;
    seq       = 0;
    while (words_sent < ITEM_TARGET) begin
      phase = (words_sent - rand_base) * 4 / (ITEM_TARGET - rand_base);
      case (phase)
        1:       idle_pct = 70;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase

      if (seq % 4 == 0) begin
        roll = $urandom_range(15);
        if (roll == 0)      write_reg(CFG_BUFFER_LENGTH, 16'($urandom_range(1, WINDOW_LEN - 1)));
        else if (roll == 1) write_reg(CFG_BUFFER_LENGTH, 16'(WINDOW_LEN));
        else if (roll == 2) write_reg(CFG_BUFFER_LENGTH, 16'(LOADED_LEN));
        else write_reg(CFG_BUFFER_LENGTH,
                       16'($urandom_range(WINDOW_LEN, LOADED_LEN)));
      end
      if (seq % 4 == 0 || $urandom_range(3) == 0) begin
        roll = $urandom_range(7);
        if (roll == 0)      write_reg(CFG_INITIAL_LIMIT, 16'd0);
        else if (roll == 1) write_reg(CFG_INITIAL_LIMIT, 16'hFFFF);
        else if (roll == 2) write_reg(CFG_INITIAL_LIMIT, 16'($urandom_range(0, 65535)));
        else                write_reg(CFG_INITIAL_LIMIT, 16'($urandom_range(1, 600)));
      end

      case ($urandom_range(3))
        0:       amp = 64;
        1:       amp = 512;
        2:       amp = 2048;
        default: amp = 8192;
      endcase

      burst = $urandom_range(0, 24);
      repeat (burst) begin
        roll = $urandom_range(31);
        smp  = draw_sample(amp);
        if (roll == 0)
          w = word_of(CMD_RESERVED, $urandom_range(0, 16383), smp);
        else if (roll == 1)
          w = word_of(CMD_WRITE_TEMPLATE, $urandom_range(WINDOW_LEN, 16383), smp);
        else if (roll == 2)
          w = word_of(CMD_WRITE_BUFFER, $urandom_range(LOADED_LEN, 16383), smp);
        else if (roll < 18)
          w = word_of(CMD_WRITE_TEMPLATE, $urandom_range(0, WINDOW_LEN - 1), smp);
        else
          w = word_of(CMD_WRITE_BUFFER, $urandom_range(0, LOADED_LEN - 1), smp);
        issue(w, 1'b0, '0);
      end
      // index and sample of a search are don't-cares; randomize them anyway
      issue(word_of(CMD_SEARCH, $urandom_range(0, 16383), 16'($urandom_range(0, 65535))),
            1'b0, '0);
      seq++;
    end

    // drain, then leave room for any stray result word
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
